[hw/rtl/rpn_pkg.sv]
// Shared constants and types of the postfix stack evaluator.
package rpn_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int DW          = 32;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(DW);
	localparam int DEPTH_OUT_W = 5;

	typedef enum logic {
		MODE_PUSH  = 1'b0,
		MODE_APPLY = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_code_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_DIV0  = 2'd2,
		ST_OVF   = 2'd3
	} status_t;

endpackage

[hw/rtl/rpn_if.sv]
// Token and result channel interfaces of the postfix stack evaluator.
interface rpn_tok_if;
	logic                         valid;
	logic                         ready;
	rpn_pkg::mode_t               mode;
	logic signed [rpn_pkg::DW-1:0] operand_value;
	rpn_pkg::op_code_t            op_code;
	logic                         last_token;

	modport source (output valid, mode, operand_value, op_code, last_token, input ready);
	modport sink   (input valid, mode, operand_value, op_code, last_token, output ready);
endinterface

interface rpn_res_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [rpn_pkg::DW-1:0]          top_value;
	logic [rpn_pkg::DEPTH_OUT_W-1:0]        stack_depth;
	rpn_pkg::status_t                       status;
	logic                                   done_res;

	modport source (output valid, top_value, stack_depth, status, done_res, input ready);
	modport sink   (input valid, top_value, stack_depth, status, done_res, output ready);
endinterface

[hw/rtl/rpn_stack_evaluator.sv]
// Postfix stack evaluator: operand stack in a synchronous RAM, top entry cached in a register.
// States per token: push S_FIN; add/sub/mul S_READ, S_FIN; divide S_READ, S_DIV, S_DFIX, S_FIN.
// One token at a time, taken only in S_IDLE; divide uses a 32-step radix-2 restoring divider.
// A finished result waits in the output register while the next token is taken.
// Asynchronous active-low reset clears stack pointer, error latch and control; RAM is not cleared.
module rpn_stack_evaluator (
	input  logic          clk,
	input  logic          arst_n,
	rpn_tok_if.sink       tok,
	rpn_res_if.source     res
);
	import rpn_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_DFIX,
		S_FIN
	} state_t;

	state_t              state_q;
	logic [SP_W-1:0]     sp_q;
	status_t             err_q;
	logic [DW-1:0]       top_q;

	// latched token
	mode_t               mode_q;
	logic [DW-1:0]       val_q;
	op_code_t            op_q;
	logic                last_q;
	status_t             item_err_q;

	// operator result and divider
	logic [DW-1:0]       res_q;
	logic [DW-1:0]       quo_q;
	logic [DW-1:0]       rem_q;
	logic [DW-1:0]       dvs_q;
	logic                neg_q;
	logic [CNT_W-1:0]    cnt_q;

	// output register
	logic                out_valid_q;
	logic [DW-1:0]       out_top_q;
	logic [DEPTH_OUT_W-1:0] out_depth_q;
	status_t             out_status_q;
	logic                out_done_q;

	// stack RAM
	logic [DW-1:0]       stack_mem [STACK_DEPTH];
	logic [DW-1:0]       rd_data_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [DW-1:0]       mem_wdata;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_raddr;

	logic                fire_tok;
	logic                slot_free;
	logic                commit;
	logic [SP_W-1:0]     nxt_sp;
	logic [DW-1:0]       nxt_top;
	status_t             nxt_err;
	logic [DW-1:0]       opa;
	logic [DW-1:0]       opb;
	logic [DW:0]         trial;

	// handshake
	assign tok.ready = (state_q == S_IDLE);
	assign fire_tok  = tok.valid && tok.ready;
	assign slot_free = !out_valid_q || res.ready;
	assign commit    = (state_q == S_FIN) && slot_free;

	assign res.valid       = out_valid_q;
	assign res.top_value   = out_top_q;
	assign res.stack_depth = out_depth_q;
	assign res.status      = out_status_q;
	assign res.done_res    = out_done_q;

	// operands of the operator: second entry from RAM, top from cache
	assign opa   = rd_data_q;
	assign opb   = top_q;
	assign trial = {rem_q, quo_q[DW-1]} - {1'b0, dvs_q};

	// read second entry when an operator with two operands is taken
	always_comb begin
		mem_re    = fire_tok && (tok.mode == MODE_APPLY) && (sp_q >= SP_W'(2));
		mem_raddr = ADDR_W'(sp_q - SP_W'(2));
	end

	// next stack state of the token in flight
	always_comb begin
		nxt_sp    = sp_q;
		nxt_top   = top_q;
		mem_we    = 1'b0;
		mem_waddr = ADDR_W'(sp_q);
		mem_wdata = val_q;
		if (item_err_q == ST_OK) begin
			if (mode_q == MODE_PUSH) begin
				nxt_sp    = sp_q + SP_W'(1);
				nxt_top   = val_q;
				mem_we    = commit;
			end else begin
				nxt_sp    = sp_q - SP_W'(1);
				nxt_top   = res_q;
				mem_we    = commit;
				mem_waddr = ADDR_W'(sp_q - SP_W'(2));
				mem_wdata = res_q;
			end
		end
		nxt_err = (err_q == ST_OK) ? item_err_q : err_q;
	end

	// stack RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			stack_mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_data_q <= stack_mem[mem_raddr];
	end

	// sequencer, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sp_q         <= '0;
			err_q        <= ST_OK;
			top_q        <= '0;
			mode_q       <= MODE_PUSH;
			val_q        <= '0;
			op_q         <= OP_ADD;
			last_q       <= 1'b0;
			item_err_q   <= ST_OK;
			res_q        <= '0;
			quo_q        <= '0;
			rem_q        <= '0;
			dvs_q        <= '0;
			neg_q        <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			out_top_q    <= '0;
			out_depth_q  <= '0;
			out_status_q <= ST_OK;
			out_done_q   <= 1'b0;
		end else begin
			// load the result at commit, drop it once taken
			if (commit)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (fire_tok) begin
						mode_q     <= tok.mode;
						val_q      <= tok.operand_value;
						op_q       <= tok.op_code;
						last_q     <= tok.last_token;
						if (tok.mode == MODE_PUSH) begin
							item_err_q <= (sp_q >= SP_W'(STACK_DEPTH)) ? ST_OVF : ST_OK;
							state_q    <= S_FIN;
						end else if (sp_q < SP_W'(2)) begin
							item_err_q <= ST_UNDER;
							state_q    <= S_FIN;
						end else begin
							item_err_q <= ST_OK;
							state_q    <= S_READ;
						end
					end
				end
				S_READ: begin
					unique case (op_q)
						OP_ADD: begin
							res_q   <= opa + opb;
							state_q <= S_FIN;
						end
						OP_SUB: begin
							res_q   <= opa - opb;
							state_q <= S_FIN;
						end
						OP_MUL: begin
							res_q   <= DW'(opa * opb);
							state_q <= S_FIN;
						end
						OP_DIV: begin
							if (opb == '0) begin
								item_err_q <= ST_DIV0;
								state_q    <= S_FIN;
							end else begin
								quo_q   <= opa[DW-1] ? (DW'(0) - opa) : opa;
								dvs_q   <= opb[DW-1] ? (DW'(0) - opb) : opb;
								rem_q   <= '0;
								neg_q   <= opa[DW-1] ^ opb[DW-1];
								cnt_q   <= CNT_W'(DW - 1);
								state_q <= S_DIV;
							end
						end
					endcase
				end
				S_DIV: begin
					// one restoring step per cycle, dividend shifts out of quo_q
					if (!trial[DW]) begin
						rem_q <= trial[DW-1:0];
						quo_q <= {quo_q[DW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
						quo_q <= {quo_q[DW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0)
						state_q <= S_DFIX;
				end
				S_DFIX: begin
					res_q   <= neg_q ? (DW'(0) - quo_q) : quo_q;
					state_q <= S_FIN;
				end
				S_FIN: begin
					// commit stack state and load the result when the slot is free
					if (slot_free) begin
						out_top_q    <= (nxt_sp != '0) ? nxt_top : '0;
						out_depth_q  <= DEPTH_OUT_W'(nxt_sp);
						out_status_q <= nxt_err;
						out_done_q   <= last_q;
						top_q        <= nxt_top;
						sp_q         <= last_q ? '0 : nxt_sp;
						err_q        <= last_q ? ST_OK : nxt_err;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_read_two: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (sp_q >= SP_W'(2)))
		else $error("operator read with fewer than two entries");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (dvs_q != '0))
		else $error("divider running on zero divisor");

	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK && !(commit && last_q)) |=> (err_q == $past(err_q)))
		else $error("latched error changed before end of expression");

	a_last_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && last_q) |=> (sp_q == '0 && err_q == ST_OK))
		else $error("stack not cleared after last token");
`endif

endmodule
